/* rtl/stft_mp_pkg.sv */
// Shared constants, CORDIC angle table and twiddle generator for the STFT block.
`default_nettype none
package stft_mp_pkg;

    localparam int CORDIC_STEPS = 24;
    localparam int SAMPLE_W     = 16;
    localparam int TW_W         = 19;   // Q1.17 twiddle, signed
    localparam int ACC_W        = 42;   // sample * twiddle summed over up to 64 points
    localparam int RE_W         = 29;   // bin value at scale 2^4
    localparam int XY_W         = 32;   // CORDIC x/y
    localparam int Z_W          = 34;   // CORDIC angle, 32-bit turn fraction plus headroom
    localparam int MAG_W        = 22;
    localparam int PHASE_W      = 16;
    localparam int BIN_W        = 6;
    localparam int HOP_W        = 11;
    localparam int WIN_W        = 7;
    localparam int CFG_DATA_W   = 11;

    localparam logic CFG_HOP_SIZE    = 1'b0;
    localparam logic CFG_WINDOW_SIZE = 1'b1;

    localparam longint GAIN_Q30     = 64'sd652032874;
    localparam longint HALF_TURN    = 64'sd2147483648;
    localparam longint QUARTER_TURN = 64'sd1073741824;
    localparam int     PI_Q13       = 25736;
    localparam longint PHASE_SCALE  = 64'sd411775;
    localparam int     MAG_MAX      = 2097152;

    localparam longint ATAN_TURNS [CORDIC_STEPS] = '{
        64'sh20000000, 64'sh12E4051E, 64'sh09FB385B, 64'sh051111D4,
        64'sh028B0D43, 64'sh0145D7E1, 64'sh00A2F61E, 64'sh00517C55,
        64'sh0028BE53, 64'sh00145F2E, 64'sh000A2F98, 64'sh000517CC,
        64'sh00028BE6, 64'sh000145F3, 64'sh0000A2F9, 64'sh0000517C,
        64'sh000028BE, 64'sh0000145F, 64'sh00000A2F, 64'sh00000517,
        64'sd652, 64'sd326, 64'sd163, 64'sd81
    };

    // cos/sin in Q1.17 of an angle given as a 32-bit turn fraction; elaboration only
    function automatic logic [2*TW_W-1:0] twiddle_q17(input longint z_turn);
        longint z;
        longint x;
        longint y;
        longint dx;
        longint dy;
        longint cr;
        longint sr;
        logic   neg;
        int     i;
        z   = z_turn;
        x   = GAIN_Q30;
        y   = 0;
        neg = 1'b0;
        if (z >= HALF_TURN) z = z - 2 * HALF_TURN;
        if (z > QUARTER_TURN) begin
            z   = z - HALF_TURN;
            neg = 1'b1;
        end else if (z < -QUARTER_TURN) begin
            z   = z + HALF_TURN;
            neg = 1'b1;
        end
        for (i = 0; i < CORDIC_STEPS; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x = x - dx;
                y = y + dy;
                z = z - ATAN_TURNS[i];
            end else begin
                x = x + dx;
                y = y - dy;
                z = z + ATAN_TURNS[i];
            end
        end
        if (neg) begin
            x = -x;
            y = -y;
        end
        cr = (x + 4096) >>> 13;
        sr = (y + 4096) >>> 13;
        return {cr[TW_W-1:0], sr[TW_W-1:0]};
    endfunction

endpackage
`default_nettype wire

/* rtl/stft_mp_mac.sv */
// Sample memory and shared multiply-accumulate unit: one DFT bin per run.
`default_nettype none
module stft_mp_mac
    import stft_mp_pkg::*;
#(
    parameter int N_FFT = 64
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          wr_en,
    input  wire logic signed [SAMPLE_W-1:0]    wr_data,
    input  wire logic                          start,
    input  wire logic [$clog2(N_FFT)-1:0]      bin_k,
    input  wire logic [$clog2(N_FFT+1)-1:0]    win_len,
    output logic                               done,
    output logic signed [RE_W-1:0]             bin_re,
    output logic signed [RE_W-1:0]             bin_im
);

    localparam int IDX_W = $clog2(N_FFT);
    localparam int CNT_W = $clog2(N_FFT + 1);

    logic signed [SAMPLE_W-1:0] mem [N_FFT];
    logic [2*TW_W-1:0]          tw_rom [N_FFT];

    for (genvar g = 0; g < N_FFT; g++) begin : g_tw
        localparam longint ZT  = (longint'(g) * 64'sd4294967296) / N_FFT;
        localparam logic [2*TW_W-1:0] TWV = twiddle_q17(ZT);
        assign tw_rom[g] = TWV;
    end

    logic [IDX_W-1:0]            wp_reg, rd_reg, t_reg, k_reg;
    logic [CNT_W-1:0]            n_reg;
    logic                        issue_reg, v1_reg, v2_reg, l1_reg, l2_reg, done_reg;
    logic signed [SAMPLE_W-1:0]  samp_reg;
    logic [2*TW_W-1:0]           tw_reg;
    logic signed [SAMPLE_W+TW_W-1:0] pre_reg, pim_reg;
    logic signed [ACC_W-1:0]     acc_re_reg, acc_im_reg;

    logic [IDX_W+1:0]            start_sum;
    logic [IDX_W-1:0]            start_ptr;
    logic [IDX_W:0]              t_sum;
    logic [IDX_W-1:0]            t_next;
    logic [IDX_W-1:0]            rd_next;
    logic [IDX_W-1:0]            wp_next;
    logic signed [ACC_W-1:0]     rnd_re, rnd_im;

    // wp points at the oldest sample, so the frame starts w entries back from it
    always_comb begin
        start_sum = (IDX_W+2)'(wp_reg) + (IDX_W+2)'(N_FFT) - (IDX_W+2)'(win_len);
        if (start_sum >= (IDX_W+2)'(N_FFT))
            start_ptr = IDX_W'(start_sum - (IDX_W+2)'(N_FFT));
        else
            start_ptr = start_sum[IDX_W-1:0];
        t_sum = (IDX_W+1)'(t_reg) + (IDX_W+1)'(k_reg);
        if (t_sum >= (IDX_W+1)'(N_FFT))
            t_next = IDX_W'(t_sum - (IDX_W+1)'(N_FFT));
        else
            t_next = t_sum[IDX_W-1:0];
        rd_next = (rd_reg == IDX_W'(N_FFT - 1)) ? '0 : rd_reg + 1'b1;
        wp_next = (wp_reg == IDX_W'(N_FFT - 1)) ? '0 : wp_reg + 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (wr_en) mem[wp_reg] <= wr_data;
        if (issue_reg) begin
            samp_reg <= mem[rd_reg];
            tw_reg   <= tw_rom[t_reg];
        end
        if (v1_reg) begin
            pre_reg <= samp_reg * $signed(tw_reg[2*TW_W-1:TW_W]);
            pim_reg <= samp_reg * $signed(tw_reg[TW_W-1:0]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg     <= '0;
            issue_reg  <= 1'b0;
            v1_reg     <= 1'b0;
            v2_reg     <= 1'b0;
            l1_reg     <= 1'b0;
            l2_reg     <= 1'b0;
            done_reg   <= 1'b0;
            rd_reg     <= '0;
            t_reg      <= '0;
            k_reg      <= '0;
            n_reg      <= '0;
            acc_re_reg <= '0;
            acc_im_reg <= '0;
        end else begin
            if (wr_en) wp_reg <= wp_next;
            v1_reg   <= issue_reg;
            l1_reg   <= issue_reg && (n_reg == CNT_W'(1));
            v2_reg   <= v1_reg;
            l2_reg   <= l1_reg;
            done_reg <= v2_reg && l2_reg;
            if (start) begin
                rd_reg     <= start_ptr;
                t_reg      <= '0;
                k_reg      <= bin_k;
                n_reg      <= win_len;
                issue_reg  <= 1'b1;
                acc_re_reg <= '0;
                acc_im_reg <= '0;
            end else if (issue_reg) begin
                rd_reg <= rd_next;
                t_reg  <= t_next;
                n_reg  <= n_reg - 1'b1;
                if (n_reg == CNT_W'(1)) issue_reg <= 1'b0;
            end
            if (v2_reg) begin
                acc_re_reg <= acc_re_reg + ACC_W'(pre_reg);
                acc_im_reg <= acc_im_reg - ACC_W'(pim_reg);
            end
        end
    end

    assign rnd_re = acc_re_reg + ACC_W'(4096);
    assign rnd_im = acc_im_reg + ACC_W'(4096);
    assign bin_re = rnd_re[ACC_W-1:13];
    assign bin_im = rnd_im[ACC_W-1:13];
    assign done   = done_reg;

endmodule
`default_nettype wire

/* rtl/stft_mp_polar.sv */
// Iterative CORDIC vectoring unit: bin value to saturated magnitude and Q3.13 phase.
`default_nettype none
module stft_mp_polar
    import stft_mp_pkg::*;
(
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       start,
    input  wire logic signed [RE_W-1:0]     bin_re,
    input  wire logic signed [RE_W-1:0]     bin_im,
    output logic                            done,
    output logic [MAG_W-1:0]                mag,
    output logic signed [PHASE_W-1:0]       phase
);

    typedef enum logic [3:0] {
        P_IDLE = 4'b0001,
        P_ITER = 4'b0010,
        P_MUL  = 4'b0100,
        P_FIN  = 4'b1000
    } pol_state_t;

    pol_state_t               state_reg;
    logic [4:0]               step_reg;
    logic signed [XY_W-1:0]   x_reg, y_reg;
    logic signed [Z_W-1:0]    z_reg;
    logic [60:0]              mm_reg;
    logic signed [53:0]       pm_reg;
    logic                     done_reg;
    logic [MAG_W-1:0]         mag_reg;
    logic signed [PHASE_W-1:0] phase_reg;

    logic signed [XY_W-1:0]   dx, dy, re_x, im_x;
    logic signed [Z_W-1:0]    atan_z, z_wrap;
    logic [30:0]              x_pos;
    logic [RE_W-1:0]          re_abs;
    logic [RE_W-1:0]          re_mag;
    logic [61:0]              mm_rnd;
    logic signed [54:0]       pm_rnd;
    logic signed [19:0]       ph_full;
    longint                   atan_full;

    always_comb begin
        re_x      = XY_W'(bin_re);
        im_x      = XY_W'(bin_im);
        dx        = y_reg >>> step_reg;
        dy        = x_reg >>> step_reg;
        atan_full = ATAN_TURNS[step_reg];
        atan_z    = atan_full[Z_W-1:0];
        if (z_reg >= Z_W'(HALF_TURN))
            z_wrap = z_reg - Z_W'(2 * HALF_TURN);
        else if (z_reg < -Z_W'(HALF_TURN))
            z_wrap = z_reg + Z_W'(2 * HALF_TURN);
        else
            z_wrap = z_reg;
        x_pos   = x_reg[XY_W-1] ? '0 : x_reg[30:0];
        re_abs  = bin_re[RE_W-1] ? RE_W'(-bin_re) : RE_W'(bin_re);
        re_mag  = (re_abs + RE_W'(8)) >> 4;
        mm_rnd  = {1'b0, mm_reg} + (62'd1 << 33);
        pm_rnd  = 55'(pm_reg) + (55'sd1 <<< 34);
        ph_full = pm_rnd[54:35];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= P_IDLE;
            done_reg  <= 1'b0;
            step_reg  <= '0;
            mag_reg   <= '0;
            phase_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            unique case (state_reg)
                P_IDLE: begin
                    if (start) begin
                        if (bin_im == '0) begin
                            // on the real axis: no rotation needed
                            mag_reg   <= (re_mag > RE_W'(MAG_MAX)) ? MAG_W'(MAG_MAX)
                                                                    : MAG_W'(re_mag);
                            phase_reg <= bin_re[RE_W-1] ? PHASE_W'(PI_Q13) : '0;
                            done_reg  <= 1'b1;
                        end else begin
                            if (bin_re[RE_W-1]) begin
                                x_reg <= -re_x;
                                y_reg <= -im_x;
                                z_reg <= Z_W'(HALF_TURN);
                            end else begin
                                x_reg <= re_x;
                                y_reg <= im_x;
                                z_reg <= '0;
                            end
                            step_reg  <= '0;
                            state_reg <= P_ITER;
                        end
                    end
                end
                P_ITER: begin
                    if (y_reg > 0) begin
                        x_reg <= x_reg + dx;
                        y_reg <= y_reg - dy;
                        z_reg <= z_reg + atan_z;
                    end else begin
                        x_reg <= x_reg - dx;
                        y_reg <= y_reg + dy;
                        z_reg <= z_reg - atan_z;
                    end
                    step_reg <= step_reg + 1'b1;
                    if (step_reg == 5'(CORDIC_STEPS - 1)) state_reg <= P_MUL;
                end
                P_MUL: begin
                    mm_reg    <= 61'(x_pos) * 61'(GAIN_Q30);
                    pm_reg    <= 54'(z_wrap) * 54'(PHASE_SCALE);
                    state_reg <= P_FIN;
                end
                P_FIN: begin
                    if (mm_rnd[61:34] > 28'(MAG_MAX))
                        mag_reg <= MAG_W'(MAG_MAX);
                    else
                        mag_reg <= mm_rnd[34+MAG_W-1:34];
                    if (ph_full > 20'sd25736)
                        phase_reg <= PHASE_W'(PI_Q13);
                    else if (ph_full < -20'sd25736)
                        phase_reg <= -PHASE_W'(PI_Q13);
                    else
                        phase_reg <= ph_full[PHASE_W-1:0];
                    done_reg  <= 1'b1;
                    state_reg <= P_IDLE;
                end
                default: state_reg <= P_IDLE;
            endcase
        end
    end

    assign done  = done_reg;
    assign mag   = mag_reg;
    assign phase = phase_reg;

endmodule
`default_nettype wire

/* rtl/stft_magnitude_phase_top.sv */
// Streaming STFT magnitude/phase: framing sequencer, MAC unit, CORDIC unit, result register.
//
// Input: one Q1.15 sample word per s_valid/s_ready handshake. Output: one word per bin
// 0..N_FFT/2 with bin index, magnitude, Q3.13 phase and a last-bin flag, on m_valid/m_ready.
// A sample that completes no frame is taken and s_ready stays high, so such
// samples can follow back to back.
// A sample that completes a frame starts the transform; s_ready stays low until the last
// bin is in the output register. Per bin: a start state, W samples through the shared
// multiply-accumulate unit (W = effective window length), then 24 CORDIC steps, a scaling
// multiply, rounding and saturation, the done flag and the load of the output register;
// the CORDIC steps and scaling are skipped when the imaginary part is zero. The single
// sample memory read port and the one CORDIC stage mean bins are computed one by one.
// A stalled receiver holds the current result; the next bin waits until it is taken,
// and after the last bin the input side is open again while that word is pending.
// Configuration writes (hop, window) are taken only while the block is idle and restart
// framing; s_ready is low in a cycle with cfg_wr_en high. Reset (aresetn low, synchronous)
// empties the output, restarts framing and loads hop 16, window 64. No clearing pass is
// needed.
`default_nettype none
module stft_magnitude_phase_top
    import stft_mp_pkg::*;
#(
    parameter int N_FFT = 64
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        cfg_wr_en,
    input  wire logic                        cfg_index,
    input  wire logic [CFG_DATA_W-1:0]       cfg_data,
    input  wire logic                        s_valid,
    output logic                             s_ready,
    input  wire logic signed [SAMPLE_W-1:0]  s_sample,
    output logic                             m_valid,
    input  wire logic                        m_ready,
    output logic [BIN_W-1:0]                 m_bin_index,
    output logic [MAG_W-1:0]                 m_magnitude,
    output logic signed [PHASE_W-1:0]        m_phase,
    output logic                             m_last_bin
);

    localparam int IDX_W = $clog2(N_FFT);
    localparam int CNT_W = $clog2(N_FFT + 1);

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_START = 5'b00010,
        ST_MAC   = 5'b00100,
        ST_POL   = 5'b01000,
        ST_OUT   = 5'b10000
    } top_state_t;

    function automatic logic [CNT_W-1:0] eff_win(input logic [WIN_W-1:0] v);
        if (v == '0) return CNT_W'(1);
        if (v > WIN_W'(N_FFT)) return CNT_W'(N_FFT);
        return v[CNT_W-1:0];
    endfunction

    top_state_t          state_reg;
    logic [HOP_W-1:0]    hop_reg, suf_reg;
    logic [WIN_W-1:0]    win_reg;
    logic [CNT_W-1:0]    filled_reg, filled_next;
    logic [IDX_W-1:0]    k_reg;
    logic                m_valid_reg;
    logic [BIN_W-1:0]    bin_reg;
    logic [MAG_W-1:0]    mag_reg;
    logic signed [PHASE_W-1:0] phase_reg;
    logic                last_reg;

    logic [CNT_W-1:0]    w_eff;
    logic [HOP_W-1:0]    hop_eff;
    logic                accept;
    logic                mac_done, pol_done;
    logic signed [RE_W-1:0] bin_re, bin_im;
    logic [MAG_W-1:0]    pol_mag;
    logic signed [PHASE_W-1:0] pol_phase;
    logic                out_free;
    logic                is_last;

    assign w_eff    = eff_win(win_reg);
    assign hop_eff  = (hop_reg == '0) ? HOP_W'(1) : hop_reg;
    assign s_ready  = (state_reg == ST_IDLE) && !cfg_wr_en;
    assign accept   = s_valid && s_ready;
    assign filled_next = (filled_reg < CNT_W'(N_FFT)) ? filled_reg + 1'b1 : filled_reg;
    assign out_free = !m_valid_reg || m_ready;
    assign is_last  = (k_reg == IDX_W'(N_FFT / 2));

    stft_mp_mac #(.N_FFT(N_FFT)) u_mac (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (accept),
        .wr_data (s_sample),
        .start   (state_reg == ST_START),
        .bin_k   (k_reg),
        .win_len (w_eff),
        .done    (mac_done),
        .bin_re  (bin_re),
        .bin_im  (bin_im)
    );

    stft_mp_polar u_polar (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (state_reg == ST_MAC && mac_done),
        .bin_re  (bin_re),
        .bin_im  (bin_im),
        .done    (pol_done),
        .mag     (pol_mag),
        .phase   (pol_phase)
    );

    always_ff @(posedge aclk) begin
        if (state_reg == ST_OUT && out_free) begin
            bin_reg   <= BIN_W'(k_reg);
            mag_reg   <= pol_mag;
            phase_reg <= pol_phase;
            last_reg  <= is_last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            hop_reg     <= HOP_W'(16);
            win_reg     <= WIN_W'(64);
            suf_reg     <= HOP_W'(eff_win(WIN_W'(64)));
            filled_reg  <= '0;
            k_reg       <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (state_reg == ST_OUT && out_free) m_valid_reg <= 1'b1;
            else if (m_ready) m_valid_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE: begin
                    if (cfg_wr_en) begin
                        filled_reg <= '0;
                        if (cfg_index == CFG_HOP_SIZE) begin
                            hop_reg <= cfg_data;
                            suf_reg <= HOP_W'(w_eff);
                        end else begin
                            win_reg <= cfg_data[WIN_W-1:0];
                            suf_reg <= HOP_W'(eff_win(cfg_data[WIN_W-1:0]));
                        end
                    end else if (accept) begin
                        filled_reg <= filled_next;
                        if (suf_reg > HOP_W'(1)) begin
                            suf_reg <= suf_reg - 1'b1;
                        end else begin
                            suf_reg <= hop_eff;
                            if (filled_next >= w_eff) begin
                                k_reg     <= '0;
                                state_reg <= ST_START;
                            end
                        end
                    end
                end
                ST_START: state_reg <= ST_MAC;
                ST_MAC:   if (mac_done) state_reg <= ST_POL;
                ST_POL:   if (pol_done) state_reg <= ST_OUT;
                ST_OUT: begin
                    if (out_free) begin
                        if (is_last) begin
                            state_reg <= ST_IDLE;
                        end else begin
                            k_reg     <= k_reg + 1'b1;
                            state_reg <= ST_START;
                        end
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_bin_index = bin_reg;
    assign m_magnitude = mag_reg;
    assign m_phase     = phase_reg;
    assign m_last_bin  = last_reg;

endmodule
`default_nettype wire

/* rtl/stft_mp_checker.sv */
// Port-level checks for the STFT block, bound to the top level.
`default_nettype none
module stft_mp_checker
    import stft_mp_pkg::*;
#(
    parameter int N_FFT = 64
) (
    input wire logic                        aclk,
    input wire logic                        aresetn,
    input wire logic                        s_valid,
    input wire logic                        s_ready,
    input wire logic signed [SAMPLE_W-1:0]  s_sample,
    input wire logic                        m_valid,
    input wire logic                        m_ready,
    input wire logic [BIN_W-1:0]            m_bin_index,
    input wire logic [MAG_W-1:0]            m_magnitude,
    input wire logic signed [PHASE_W-1:0]   m_phase,
    input wire logic                        m_last_bin
);

    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid && $stable(s_sample))
        else $error("sample word dropped or changed while waiting");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_bin_index) && $stable(m_magnitude)
                                && $stable(m_phase) && $stable(m_last_bin))
        else $error("result word changed while stalled");

    a_last_bin: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_last_bin == (m_bin_index == BIN_W'(N_FFT / 2))))
        else $error("last-bin flag does not match bin index");

    a_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_magnitude <= MAG_W'(MAG_MAX) && m_bin_index <= BIN_W'(N_FFT / 2)
                    && m_phase <= 16'sd25736 && m_phase >= -16'sd25736)
        else $error("result field out of range");

    // a word shown right after a taken non-final bin is the next bin
    a_bin_order: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_last_bin
        |=> !m_valid || m_bin_index == $past(m_bin_index) + 1'b1)
        else $error("bins out of order");

endmodule

bind stft_magnitude_phase_top stft_mp_checker #(.N_FFT(N_FFT)) u_stft_mp_checker (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .s_valid     (s_valid),
    .s_ready     (s_ready),
    .s_sample    (s_sample),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_bin_index (m_bin_index),
    .m_magnitude (m_magnitude),
    .m_phase     (m_phase),
    .m_last_bin  (m_last_bin)
);
`default_nettype wire
